FILE: rtl/srf_pkg.sv
// srf_pkg: sizes, field widths and operation codes of the sample ring fifo
// no dependencies; used by the channel interfaces and by sample_ring_fifo
package srf_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int SAMPLE_BITS = 32;
  localparam int MAX_BURST   = 64;

  localparam int ADDR_BITS  = $clog2(STORE_DEPTH);
  localparam int SPAN_BITS  = ADDR_BITS + 1;
  localparam int CAP_BITS   = 10;
  localparam int COUNT_BITS = 7;
  localparam int FILL_BITS  = 10;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(1023);

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_SILENCE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_t;

endpackage

FILE: rtl/srf_if.sv
// srf channel interfaces: request items, result items and capacity writes
// depends on srf_pkg for field widths and the mode code type
interface srf_req_if import srf_pkg::*;;
  logic                   valid;
  logic                   ready;
  mode_t                  mode;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic [COUNT_BITS-1:0]  count;

  modport source (output valid, mode, sample_in, count, input ready);
  modport sink (input valid, mode, sample_in, count, output ready);
endinterface

interface srf_rsp_if import srf_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   sample_valid;
  logic [COUNT_BITS-1:0]  done_count;
  logic [FILL_BITS-1:0]   fill_level;
  logic                   last;

  modport source (output valid, sample_out, sample_valid, done_count, fill_level, last,
                  input ready);
  modport sink (input valid, sample_out, sample_valid, done_count, fill_level, last,
                output ready);
endinterface

interface srf_cfg_if import srf_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CAP_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/sample_ring_fifo.sv
// sample_ring_fifo: sample fifo in a single-port-write ring memory with head and tail pointers
// depends on srf_pkg and the channel interfaces in srf_if.sv
// write, discard and empty items give their registered result in the cycle after acceptance
// those items are accepted back to back while results do not stall; silence of n samples ends in one result
// read of n samples: one sample per cycle through the memory read register while results do not stall
// reset: pointers to zero, capacity 1023; ring contents undefined until written, no clearing pass
module sample_ring_fifo import srf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  srf_req_if.sink   req,
  srf_rsp_if.source rsp,
  srf_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {ST_IDLE, ST_SILENCE, ST_READ} state_t;

  logic [SAMPLE_BITS-1:0] ring [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;

  state_t                 state;
  logic [ADDR_BITS-1:0]   wp;
  logic [ADDR_BITS-1:0]   rp;
  logic [SPAN_BITS-1:0]   span;
  logic [COUNT_BITS-1:0]  rem;
  logic [COUNT_BITS-1:0]  item_done;
  logic [FILL_BITS-1:0]   item_fill;
  logic                   q_valid;
  logic                   q_last;
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic                   out_svalid;
  logic [COUNT_BITS-1:0]  out_done;
  logic [FILL_BITS-1:0]   out_fill;
  logic                   out_last;

  logic [SPAN_BITS-1:0]   fill_w;
  logic [SPAN_BITS-1:0]   room_w;
  logic [COUNT_BITS-1:0]  want;
  logic [COUNT_BITS-1:0]  min_fill;
  logic [COUNT_BITS-1:0]  min_room;
  logic [COUNT_BITS-1:0]  done_w;
  logic [FILL_BITS-1:0]   fill_after;
  logic [ADDR_BITS-1:0]   wp_inc;
  logic [ADDR_BITS-1:0]   rp_inc;
  logic [ADDR_BITS-1:0]   rp_skip;
  logic [SPAN_BITS-1:0]   rp_sum;
  logic [SPAN_BITS-1:0]   span_cfg;
  logic [SPAN_BITS-1:0]   cap_plus;
  logic                   accept;
  logic                   out_free;
  logic                   q_move;
  logic                   issue;
  logic                   sil_step;
  logic                   out_set;
  logic                   wr_en;
  logic [SAMPLE_BITS-1:0] wr_data;

  // occupancy and free space from the pointers
  always_comb begin
    if (wp >= rp) begin
      fill_w = {1'b0, wp} - {1'b0, rp};
    end else begin
      fill_w = span + {1'b0, wp} - {1'b0, rp};
    end
    room_w = span - SPAN_BITS'(1) - fill_w;
  end

  assign want     = (req.count > COUNT_BITS'(MAX_BURST)) ? COUNT_BITS'(MAX_BURST) : req.count;
  assign min_fill = (SPAN_BITS'(want) < fill_w) ? want : COUNT_BITS'(fill_w);
  assign min_room = (SPAN_BITS'(want) < room_w) ? want : COUNT_BITS'(room_w);

  always_comb begin
    unique case (req.mode)
      MODE_WRITE:   done_w = (room_w != '0) ? COUNT_BITS'(1) : '0;
      MODE_SILENCE: done_w = min_room;
      MODE_READ:    done_w = min_fill;
      MODE_DISCARD: done_w = min_fill;
      default:      done_w = '0;
    endcase
  end

  assign fill_after = (req.mode == MODE_READ || req.mode == MODE_DISCARD)
                      ? FILL_BITS'(fill_w - SPAN_BITS'(done_w))
                      : FILL_BITS'(fill_w + SPAN_BITS'(done_w));

  // pointer steps with wrap at the ring span
  assign wp_inc  = ({1'b0, wp} + SPAN_BITS'(1) == span) ? '0 : wp + ADDR_BITS'(1);
  assign rp_inc  = ({1'b0, rp} + SPAN_BITS'(1) == span) ? '0 : rp + ADDR_BITS'(1);
  assign rp_sum  = {1'b0, rp} + SPAN_BITS'(done_w);
  assign rp_skip = (rp_sum >= span) ? ADDR_BITS'(rp_sum - span) : ADDR_BITS'(rp_sum);

  assign cap_plus = {1'b0, cfg.data} + SPAN_BITS'(1);
  assign span_cfg = (cap_plus > SPAN_BITS'(STORE_DEPTH)) ? SPAN_BITS'(STORE_DEPTH) : cap_plus;

  // handshakes
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && !q_valid && out_free && !cfg.valid;
  assign cfg.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign q_move    = q_valid && out_free;
  assign issue     = (state == ST_READ) && (!q_valid || q_move);
  assign sil_step  = (state == ST_SILENCE) && ((rem != COUNT_BITS'(1)) || out_free);

  // output register loaded this cycle
  assign out_set = q_move || (sil_step && rem == COUNT_BITS'(1))
                   || (accept && !(done_w != '0 &&
                                   (req.mode == MODE_READ || req.mode == MODE_SILENCE)));

  assign wr_en   = (accept && req.mode == MODE_WRITE && room_w != '0) || sil_step;
  assign wr_data = (state == ST_SILENCE) ? '0 : req.sample_in;

  assign rsp.valid        = out_valid;
  assign rsp.sample_out   = out_sample;
  assign rsp.sample_valid = out_svalid;
  assign rsp.done_count   = out_done;
  assign rsp.fill_level   = out_fill;
  assign rsp.last         = out_last;

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wp] <= wr_data;
    end
    if (issue) begin
      rd_data <= ring[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      span      <= {1'b0, CAP_RESET} + SPAN_BITS'(1);
      rem       <= '0;
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !out_set) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        span <= span_cfg;
        wp   <= '0;
        rp   <= '0;
      end
      if (q_move) begin
        out_valid  <= 1'b1;
        out_sample <= rd_data;
        out_svalid <= 1'b1;
        out_done   <= item_done;
        out_fill   <= item_fill;
        out_last   <= q_last;
        if (!issue) begin
          q_valid <= 1'b0;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item_done <= done_w;
            item_fill <= fill_after;
            if (req.mode == MODE_READ && done_w != '0) begin
              state <= ST_READ;
              rem   <= done_w;
            end else if (req.mode == MODE_SILENCE && done_w != '0) begin
              state <= ST_SILENCE;
              rem   <= done_w;
            end else begin
              out_valid  <= 1'b1;
              out_sample <= '0;
              out_svalid <= 1'b0;
              out_done   <= done_w;
              out_fill   <= fill_after;
              out_last   <= 1'b1;
              if (req.mode == MODE_WRITE && room_w != '0) begin
                wp <= wp_inc;
              end
              if (req.mode == MODE_DISCARD) begin
                rp <= rp_skip;
              end
            end
          end
        end
        ST_SILENCE: begin
          if (sil_step) begin
            wp  <= wp_inc;
            rem <= rem - COUNT_BITS'(1);
            if (rem == COUNT_BITS'(1)) begin
              state      <= ST_IDLE;
              out_valid  <= 1'b1;
              out_sample <= '0;
              out_svalid <= 1'b0;
              out_done   <= item_done;
              out_fill   <= item_fill;
              out_last   <= 1'b1;
            end
          end
        end
        ST_READ: begin
          if (issue) begin
            q_valid <= 1'b1;
            q_last  <= (rem == COUNT_BITS'(1));
            rp      <= rp_inc;
            rem     <= rem - COUNT_BITS'(1);
            if (rem == COUNT_BITS'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/testbench.sv
// testbench for sample_ring_fifo: directed table, then random phases over several capacities
// predicts result items in-house or takes them from the table, and checks them in order on the result channel
// depends on srf_pkg, the channel interfaces in srf_if.sv and the sample_ring_fifo rtl
module testbench import srf_pkg::*;;

  localparam int LONG_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES    = 8;
  localparam int PRINT_LIMIT      = 60;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   sample_valid;
    logic [COUNT_BITS-1:0]  done_count;
    logic [FILL_BITS-1:0]   fill_level;
    logic                   last;
  } fifo_result_t;

  typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    mode_t                  mode;
    logic [SAMPLE_BITS-1:0] sample;
    logic [COUNT_BITS-1:0]  count;
    bit                     typed;
    fifo_result_t           want;
  } stim_row_t;

  logic clk;
  logic rst;

  srf_req_if req_ch();
  srf_rsp_if rsp_ch();
  srf_cfg_if cfg_ch();

  sample_ring_fifo DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // in-house copy of the fifo
  logic [SAMPLE_BITS-1:0] ring_copy [STORE_DEPTH];
  int unsigned            head_ptr;
  int unsigned            tail_ptr;
  int unsigned            capacity_now;

  fifo_result_t pending_results[$];
  stim_row_t    plan[$];

  int  mismatches;
  int  items_sent;
  int  results_checked;
  int  cap_writes;
  bit  quiet;
  bit  long_hold;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("tb: mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void predict_fifo_op(input mode_t m, input logic [SAMPLE_BITS-1:0] s,
                                          input logic [COUNT_BITS-1:0] c,
                                          output fifo_result_t outs[$]);
    int unsigned  span;
    int unsigned  fill;
    int unsigned  room;
    int unsigned  want;
    int unsigned  done;
    int unsigned  i;
    fifo_result_t r;
    outs = {};
    span = (capacity_now + 1 > STORE_DEPTH) ? STORE_DEPTH : capacity_now + 1;
    fill = (span + head_ptr - tail_ptr) % span;
    room = span - 1 - fill;
    want = (c > MAX_BURST) ? MAX_BURST : c;
    done = 0;
    case (m)
      MODE_WRITE: begin
        if (room > 0) begin
          ring_copy[head_ptr] = s;
          head_ptr = (head_ptr + 1) % span;
          done = 1;
        end
      end
      MODE_SILENCE: begin
        done = (want < room) ? want : room;
        for (i = 0; i < done; i++) begin
          ring_copy[head_ptr] = '0;
          head_ptr = (head_ptr + 1) % span;
        end
      end
      default: begin
        done = (want < fill) ? want : fill;
        if (m == MODE_READ && done > 0) begin
          for (i = 0; i < done; i++) begin
            r.sample_out   = ring_copy[tail_ptr];
            r.sample_valid = 1'b1;
            r.done_count   = COUNT_BITS'(done);
            r.fill_level   = FILL_BITS'(fill - done);
            r.last         = (i + 1 == done);
            outs.push_back(r);
            tail_ptr = (tail_ptr + 1) % span;
          end
          return;
        end
        tail_ptr = (tail_ptr + done) % span;
      end
    endcase
    r.sample_out   = '0;
    r.sample_valid = 1'b0;
    r.done_count   = COUNT_BITS'(done);
    r.fill_level   = FILL_BITS'((span + head_ptr - tail_ptr) % span);
    r.last         = 1'b1;
    outs.push_back(r);
  endfunction

  // starts and ends at a falling edge; valid stays high when items follow back to back
  task automatic send_item(input mode_t m, input logic [SAMPLE_BITS-1:0] s,
                           input logic [COUNT_BITS-1:0] c, input bit typed,
                           input fifo_result_t want);
    fifo_result_t outs[$];
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= m;
    req_ch.sample_in <= s;
    req_ch.count     <= c;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_fifo_op(m, s, c, outs);
    if (typed)
      pending_results.push_back(want);
    else
      foreach (outs[k]) pending_results.push_back(outs[k]);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    capacity_now = value;
    head_ptr     = 0;
    tail_ptr     = 0;
    cap_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random(input int fill_bias);
    mode_t                 m;
    logic [COUNT_BITS-1:0] c;
    int unsigned           r;
    r = $urandom_range(0, 99);
    if (r < fill_bias)
      m = ($urandom_range(0, 9) < 7) ? MODE_SILENCE : MODE_WRITE;
    else
      m = ($urandom_range(0, 3) == 0) ? MODE_DISCARD : MODE_READ;
    r = $urandom_range(0, 19);
    if (r == 0)
      c = '0;
    else if (r < 3)
      c = COUNT_BITS'($urandom_range(65, 127));
    else if (capacity_now < 62)
      c = COUNT_BITS'($urandom_range(1, capacity_now + 2));
    else
      c = COUNT_BITS'($urandom_range(1, 64));
    send_item(m, $urandom, c, 1'b0, '0);
  endtask

  task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int n, input int fill_bias);
    write_capacity(cap);
    repeat (n) send_random(fill_bias);
  endtask

  function automatic stim_row_t row(input row_kind_t kind, input mode_t m,
                                    input logic [SAMPLE_BITS-1:0] s,
                                    input logic [COUNT_BITS-1:0] c, input bit typed,
                                    input logic [SAMPLE_BITS-1:0] sout, input logic svalid,
                                    input int done, input int fill);
    stim_row_t t;
    t.kind  = kind;
    t.mode  = m;
    t.sample = s;
    t.count = c;
    t.typed = typed;
    t.want  = '{sout, svalid, COUNT_BITS'(done), FILL_BITS'(fill), 1'b1};
    return t;
  endfunction

  // result receiver: random stall bursts, one long hold on request
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    fifo_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result item with nothing expected");
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (rsp_ch.sample_out !== want.sample_out)
          flag_mismatch($sformatf("sample_out got %h want %h", rsp_ch.sample_out,
                                  want.sample_out));
        if (rsp_ch.sample_valid !== want.sample_valid)
          flag_mismatch($sformatf("sample_valid got %b want %b", rsp_ch.sample_valid,
                                  want.sample_valid));
        if (rsp_ch.done_count !== want.done_count)
          flag_mismatch($sformatf("done_count got %0d want %0d", rsp_ch.done_count,
                                  want.done_count));
        if (rsp_ch.fill_level !== want.fill_level)
          flag_mismatch($sformatf("fill_level got %0d want %0d", rsp_ch.fill_level,
                                  want.fill_level));
        if (rsp_ch.last !== want.last)
          flag_mismatch($sformatf("last got %b want %b", rsp_ch.last, want.last));
      end
    end
  end

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.mode      = MODE_WRITE;
    req_ch.sample_in = '0;
    req_ch.count     = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    capacity_now     = CAP_RESET;
    head_ptr         = 0;
    tail_ptr         = 0;
    mismatches       = 0;
    items_sent       = 0;
    results_checked  = 0;
    cap_writes       = 0;
    quiet            = 1'b0;
    long_hold        = 1'b0;

    // capacity rows carry the new value in the sample column
    // at reset capacity, empty fifo
    plan.push_back(row(ROW_OP,  MODE_READ,    32'h0,        7'd5,   1, 32'h0, 0, 0, 0));
    plan.push_back(row(ROW_OP,  MODE_DISCARD, 32'h0,        7'd3,   1, 32'h0, 0, 0, 0));
    plan.push_back(row(ROW_OP,  MODE_WRITE,   32'hFFFFFFFF, 7'd1,   1, 32'h0, 0, 1, 1));
    plan.push_back(row(ROW_OP,  MODE_WRITE,   32'h00000000, 7'd127, 1, 32'h0, 0, 1, 2));
    plan.push_back(row(ROW_OP,  MODE_SILENCE, 32'h0,        7'd0,   1, 32'h0, 0, 0, 2));
    plan.push_back(row(ROW_OP,  MODE_SILENCE, 32'h0,        7'd3,   1, 32'h0, 0, 3, 5));
    plan.push_back(row(ROW_OP,  MODE_READ,    32'h0,        7'd1,   1, 32'hFFFFFFFF, 1, 1, 4));
    plan.push_back(row(ROW_OP,  MODE_READ,    32'h0,        7'd0,   1, 32'h0, 0, 0, 4));
    plan.push_back(row(ROW_OP,  MODE_READ,    32'h0,        7'd127, 0, 32'h0, 0, 0, 0));
    // oversized counts clamp to the burst limit
    plan.push_back(row(ROW_OP,  MODE_SILENCE, 32'h0,        7'd127, 1, 32'h0, 0, 64, 64));
    plan.push_back(row(ROW_OP,  MODE_DISCARD, 32'h0,        7'd100, 1, 32'h0, 0, 64, 0));
    plan.push_back(row(ROW_OP,  MODE_WRITE,   32'hA5A55A5A, 7'd0,   1, 32'h0, 0, 1, 1));
    plan.push_back(row(ROW_OP,  MODE_WRITE,   32'h12345678, 7'd64,  0, 32'h0, 0, 0, 0));
    plan.push_back(row(ROW_OP,  MODE_READ,    32'h0,        7'd64,  0, 32'h0, 0, 0, 0));
    // zero capacity: always empty and full at once
    plan.push_back(row(ROW_CAP, MODE_WRITE,   32'd0,        7'd0,   0, 32'h0, 0, 0, 0));
    plan.push_back(row(ROW_OP,  MODE_WRITE,   32'hDEADBEEF, 7'd1,   1, 32'h0, 0, 0, 0));
    plan.push_back(row(ROW_OP,  MODE_SILENCE, 32'h0,        7'd10,  1, 32'h0, 0, 0, 0));
    plan.push_back(row(ROW_OP,  MODE_READ,    32'h0,        7'd10,  1, 32'h0, 0, 0, 0));
    // capacity one: second write is dropped
    plan.push_back(row(ROW_CAP, MODE_WRITE,   32'd1,        7'd0,   0, 32'h0, 0, 0, 0));
    plan.push_back(row(ROW_OP,  MODE_WRITE,   32'h80000001, 7'd1,   1, 32'h0, 0, 1, 1));
    plan.push_back(row(ROW_OP,  MODE_WRITE,   32'h7FFFFFFE, 7'd1,   1, 32'h0, 0, 0, 1));
    plan.push_back(row(ROW_OP,  MODE_SILENCE, 32'h0,        7'd5,   1, 32'h0, 0, 0, 1));
    plan.push_back(row(ROW_OP,  MODE_READ,    32'h0,        7'd3,   1, 32'h80000001, 1, 1, 0));
    plan.push_back(row(ROW_OP,  MODE_DISCARD, 32'h0,        7'd0,   1, 32'h0, 0, 0, 0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAP)
        write_capacity(plan[i].sample[CAP_BITS-1:0]);
      else
        send_item(plan[i].mode, plan[i].sample, plan[i].count, plan[i].typed, plan[i].want);
    end

    // full-size ring: fill, drain, fill again so the pointers wrap
    write_capacity(10'd1023);
    repeat (30) send_random(90);
    repeat (10) send_random(5);
    repeat (15) send_random(90);

    run_phase(10'd2, 18, 55);

    // long result stall while writes keep coming, so the input backs up
    write_capacity(10'd700);
    long_hold = 1'b1;
    repeat (24) send_item(MODE_WRITE, $urandom, 7'd1, 1'b0, '0);
    repeat (6) send_random(10);

    run_phase(10'd1, 15, 50);
    run_phase(10'd37, 20, 60);
    run_phase(10'd0, 6, 50);

    quiet = 1'b1;
    run_phase(10'd300, 20, 55);

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d items sent, %0d result items checked, %0d mismatches",
             items_sent, results_checked, mismatches);
    $display("tb: %0d capacity writes incl. 0, 1 and 1023, one long result stall",
             cap_writes);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
